@@ design/dual_camera_pose_variance_gate_defines.svh @@
// assertion helpers shared by the gate modules
`ifndef DUAL_CAMERA_POSE_VARIANCE_GATE_DEFINES_SVH
`define DUAL_CAMERA_POSE_VARIANCE_GATE_DEFINES_SVH

// generic clocked assertion with reset disable
`define DCPVG_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same on the block's own clock and reset
`define DCPVG_ASSERT_CR(name, prop, msg) `DCPVG_ASSERT(name, clk_i, rst_ni, prop, msg)

`endif

@@ design/dcpvg_pkg.sv @@
package dcpvg_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned AXES    = 3;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned SUM_W   = SMP_W + IDX_W;
  localparam int unsigned SQ_W    = 31 + IDX_W;
  localparam int unsigned VAR_W   = 2 * SUM_W;
  localparam int unsigned NN_W    = 2 * CNT_W;
  localparam int unsigned BND_W   = NN_W + 32;
  localparam int unsigned CMP_W   = (VAR_W > BND_W) ? VAR_W : BND_W;
  localparam int unsigned SUMP_W  = SUM_W + 1;
  localparam int unsigned NP_W    = CNT_W + 1;
  localparam int unsigned STEP_W  = $clog2(SUMP_W);

  localparam logic [1:0] AX_X   = 2'd0;
  localparam logic [1:0] AX_Y   = 2'd1;
  localparam logic [1:0] AX_ROT = 2'd2;

  localparam logic [1:0] SRC_BOTH  = 2'd0;
  localparam logic [1:0] SRC_LEFT  = 2'd1;
  localparam logic [1:0] SRC_RIGHT = 2'd2;

  localparam logic [2:0] REG_MIN_GOOD = 3'd0;
  localparam logic [2:0] REG_POS_LO   = 3'd1;
  localparam logic [2:0] REG_POS_HI   = 3'd2;
  localparam logic [2:0] REG_ROT_LO   = 3'd3;
  localparam logic [2:0] REG_ROT_HI   = 3'd4;

  typedef logic [AXES-1:0][SMP_W-1:0] sample_t;

  typedef struct packed {
    logic [4:0]  min_good;
    logic [31:0] pos_lo;
    logic [31:0] pos_hi;
    logic [31:0] rot_lo;
    logic [31:0] rot_hi;
  } cfg_t;

  typedef struct packed {
    logic                        pass;
    logic [CNT_W-1:0]            count;
    logic [AXES-1:0][SUM_W-1:0]  sum;
  } lane_stat_t;

endpackage

@@ design/dual_camera_pose_variance_gate.sv @@
// dual camera pose variance gate
//
// input channel (in_valid_i / in_ready_o): one request carries a valid flag and
// an x, y, heading sample from each camera. if either flag is set both samples
// go to 16-entry rings at one shared slot; then both windows are scanned and gated on
// good count and per-axis population variance.
// output channel (out_valid_o / out_ready_i): zero or one pose per request,
// with pose_source_o telling pooled, left only or right only.
// apb port: min_good_count, pos_var_low/high, rot_var_low/high at 0x0..0x10.
// write only while idle; pready is tied high.
// timing: each camera lane walks its window one entry a cycle, then forms n*n
// and, for each axis in turn, the variance products and the compare; the mean
// uses a one-bit-per-cycle divider. in_ready_o returns once the merge has
// handed its result on, which for a pose waits for room in the output register.
// the output register lets the next request be taken while a pose waits;
// a stalled receiver only holds the block once a second pose is finished.
// reset clears all window entries to not good, the ring slot to zero and
// the registers to their defaults; no clearing pass is needed.
`include "dual_camera_pose_variance_gate_defines.svh"

module dual_camera_pose_variance_gate (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input samples
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        left_valid_i,
  input  logic [15:0] left_x_i,
  input  logic [15:0] left_y_i,
  input  logic [15:0] left_rot_i,
  input  logic        right_valid_i,
  input  logic [15:0] right_x_i,
  input  logic [15:0] right_y_i,
  input  logic [15:0] right_rot_i,
  // pose result
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] pose_x_o,
  output logic [15:0] pose_y_o,
  output logic [15:0] pose_rot_o,
  output logic [1:0]  pose_source_o
);

  typedef enum logic [1:0] {T_IDLE, T_LANE, T_MERGE} top_state_e;

  top_state_e                  state_q;
  logic [dcpvg_pkg::IDX_W-1:0] slot_q;
  dcpvg_pkg::cfg_t             cfg_q;
  logic                        out_valid_q;
  dcpvg_pkg::sample_t          out_pose_q;
  logic [1:0]                  out_src_q;

  logic                        accept, wr_en, cfg_wr;
  logic [2:0]                  reg_idx;
  logic                        l_done, r_done;
  dcpvg_pkg::lane_stat_t       l_stat, r_stat;
  logic                        m_start, m_done, m_has, m_ack;
  dcpvg_pkg::sample_t          m_pose;
  logic [1:0]                  m_src;
  logic                        out_free;

  // config registers
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_good <= 5'd8;
      cfg_q.pos_lo   <= 32'h0000_0000;
      cfg_q.pos_hi   <= 32'hFFFF_FFFF;
      cfg_q.rot_lo   <= 32'h0000_0000;
      cfg_q.rot_hi   <= 32'hFFFF_FFFF;
    end else if (cfg_wr) begin
      case (reg_idx)
        dcpvg_pkg::REG_MIN_GOOD: cfg_q.min_good <= pwdata[4:0];
        dcpvg_pkg::REG_POS_LO:   cfg_q.pos_lo   <= pwdata;
        dcpvg_pkg::REG_POS_HI:   cfg_q.pos_hi   <= pwdata;
        dcpvg_pkg::REG_ROT_LO:   cfg_q.rot_lo   <= pwdata;
        dcpvg_pkg::REG_ROT_HI:   cfg_q.rot_hi   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dcpvg_pkg::REG_MIN_GOOD: prdata = {27'd0, cfg_q.min_good};
      dcpvg_pkg::REG_POS_LO:   prdata = cfg_q.pos_lo;
      dcpvg_pkg::REG_POS_HI:   prdata = cfg_q.pos_hi;
      dcpvg_pkg::REG_ROT_LO:   prdata = cfg_q.rot_lo;
      dcpvg_pkg::REG_ROT_HI:   prdata = cfg_q.rot_hi;
      default:                 prdata = 32'd0;
    endcase
  end

  // request handshake and ring slot
  assign in_ready_o = (state_q == T_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = accept && (left_valid_i || right_valid_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (wr_en) begin
      if (slot_q == dcpvg_pkg::IDX_W'(dcpvg_pkg::DEPTH - 1)) begin
        slot_q <= '0;
      end else begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  // one lane per camera
  dcpvg_lane u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .wr_en_i   (wr_en),
    .wr_slot_i (slot_q),
    .wr_good_i (left_valid_i),
    .wr_data_i ({left_rot_i, left_y_i, left_x_i}),
    .start_i   (accept),
    .done_o    (l_done),
    .stat_o    (l_stat)
  );

  dcpvg_lane u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .wr_en_i   (wr_en),
    .wr_slot_i (slot_q),
    .wr_good_i (right_valid_i),
    .wr_data_i ({right_rot_i, right_y_i, right_x_i}),
    .start_i   (accept),
    .done_o    (r_done),
    .stat_o    (r_stat)
  );

  // combine the lanes and take the mean
  assign m_start  = (state_q == T_LANE) && l_done && r_done;
  assign out_free = !out_valid_q || out_ready_i;
  assign m_ack    = m_done && (!m_has || out_free);

  dcpvg_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (m_start),
    .left_i     (l_stat),
    .right_i    (r_stat),
    .ack_i      (m_ack),
    .done_o     (m_done),
    .has_pose_o (m_has),
    .pose_o     (m_pose),
    .source_o   (m_src)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
    end else begin
      case (state_q)
        T_IDLE:  if (accept) state_q <= T_LANE;
        T_LANE:  if (m_start) state_q <= T_MERGE;
        T_MERGE: if (m_ack) state_q <= T_IDLE;
        default: state_q <= T_IDLE;
      endcase
    end
  end

  // output register, parts the receiver from the core
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (m_ack && m_has) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_ack && m_has) begin
      out_pose_q <= m_pose;
      out_src_q  <= m_src;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pose_x_o      = out_pose_q[dcpvg_pkg::AX_X];
  assign pose_y_o      = out_pose_q[dcpvg_pkg::AX_Y];
  assign pose_rot_o    = out_pose_q[dcpvg_pkg::AX_ROT];
  assign pose_source_o = out_src_q;

  `DCPVG_ASSERT_CR(a_lanes_lockstep, l_done == r_done, "camera lanes out of step")
  `DCPVG_ASSERT_CR(a_busy_after_accept, accept |=> !in_ready_o, "ready while request in flight")
  `DCPVG_ASSERT_CR(a_pose_loaded, (m_ack && m_has) |=> out_valid_o, "pose lost at output")

endmodule

@@ design/dcpvg_lane.sv @@
module dcpvg_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dcpvg_pkg::cfg_t             cfg_i,
  input  logic                        wr_en_i,
  input  logic [dcpvg_pkg::IDX_W-1:0] wr_slot_i,
  input  logic                        wr_good_i,
  input  dcpvg_pkg::sample_t          wr_data_i,
  input  logic                        start_i,
  output logic                        done_o,
  output dcpvg_pkg::lane_stat_t       stat_o
);

  typedef enum logic [2:0] {L_IDLE, L_ACC, L_NN, L_MUL, L_CMP} lane_state_e;

  logic [dcpvg_pkg::DEPTH-1:0] good_q;
  dcpvg_pkg::sample_t          data_q [dcpvg_pkg::DEPTH];

  lane_state_e                                       state_q;
  logic [dcpvg_pkg::IDX_W-1:0]                       idx_q;
  logic [dcpvg_pkg::CNT_W-1:0]                       cnt_q;
  logic [dcpvg_pkg::AXES-1:0][dcpvg_pkg::SUM_W-1:0]  sum_q;
  logic [dcpvg_pkg::AXES-1:0][dcpvg_pkg::SQ_W-1:0]   sq_q;
  logic [1:0]                                        ax_q;
  logic [dcpvg_pkg::NN_W-1:0]                        nn_q;
  logic [dcpvg_pkg::VAR_W-1:0]                       pa_q, pb_q;
  logic [dcpvg_pkg::BND_W-1:0]                       lo_q, hi_q;
  logic                                              hit_q, done_q, pass_q;

  dcpvg_pkg::sample_t                                ent;
  logic [dcpvg_pkg::AXES-1:0][dcpvg_pkg::SUM_W-1:0]  sum_d;
  logic [dcpvg_pkg::AXES-1:0][dcpvg_pkg::SQ_W-1:0]   sq_d;
  logic signed [31:0]                                sqr [dcpvg_pkg::AXES];
  logic [31:0]                                       lo_sel, hi_sel;
  logic [dcpvg_pkg::VAR_W-1:0]                       scaled;
  logic                                              in_band;
  logic                                              cnt_ok;

  // window storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q <= '0;
    end else if (wr_en_i) begin
      good_q[wr_slot_i] <= wr_good_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_good_i) begin
      data_q[wr_slot_i] <= wr_data_i;
    end
  end

  // one entry per cycle into the running sums
  always_comb begin
    ent = data_q[idx_q];
    for (int k = 0; k < dcpvg_pkg::AXES; k++) begin
      sqr[k]   = $signed(ent[k]) * $signed(ent[k]);
      sum_d[k] = sum_q[k] + {{(dcpvg_pkg::SUM_W - dcpvg_pkg::SMP_W){ent[k][15]}}, ent[k]};
      sq_d[k]  = sq_q[k] + dcpvg_pkg::SQ_W'(sqr[k][30:0]);
    end
  end

  assign lo_sel  = (ax_q == dcpvg_pkg::AX_ROT) ? cfg_i.rot_lo : cfg_i.pos_lo;
  assign hi_sel  = (ax_q == dcpvg_pkg::AX_ROT) ? cfg_i.rot_hi : cfg_i.pos_hi;
  assign scaled  = pa_q - pb_q;
  assign in_band = (dcpvg_pkg::CMP_W'(scaled) >= dcpvg_pkg::CMP_W'(lo_q)) &&
                   (dcpvg_pkg::CMP_W'(scaled) <= dcpvg_pkg::CMP_W'(hi_q));
  assign cnt_ok  = (cnt_q != '0) &&
                   (dcpvg_pkg::CNT_W'(0) + 6'(cnt_q) >= 6'(cfg_i.min_good));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      ax_q    <= dcpvg_pkg::AX_X;
      nn_q    <= '0;
      pa_q    <= '0;
      pb_q    <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      hit_q   <= 1'b0;
      done_q  <= 1'b0;
      pass_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            idx_q   <= '0;
            cnt_q   <= '0;
            sum_q   <= '0;
            sq_q    <= '0;
            hit_q   <= 1'b0;
            state_q <= L_ACC;
          end
        end
        L_ACC: begin
          if (good_q[idx_q]) begin
            cnt_q <= cnt_q + 1'b1;
            sum_q <= sum_d;
            sq_q  <= sq_d;
          end
          if (idx_q == dcpvg_pkg::IDX_W'(dcpvg_pkg::DEPTH - 1)) begin
            state_q <= L_NN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        L_NN: begin
          nn_q    <= dcpvg_pkg::NN_W'(cnt_q) * dcpvg_pkg::NN_W'(cnt_q);
          ax_q    <= dcpvg_pkg::AX_X;
          state_q <= L_MUL;
        end
        L_MUL: begin
          pa_q    <= dcpvg_pkg::VAR_W'(cnt_q) * dcpvg_pkg::VAR_W'(sq_q[ax_q]);
          pb_q    <= dcpvg_pkg::VAR_W'($signed(sum_q[ax_q]) * $signed(sum_q[ax_q]));
          lo_q    <= dcpvg_pkg::BND_W'(nn_q) * dcpvg_pkg::BND_W'(lo_sel);
          hi_q    <= dcpvg_pkg::BND_W'(nn_q) * dcpvg_pkg::BND_W'(hi_sel);
          state_q <= L_CMP;
        end
        L_CMP: begin
          if (ax_q == dcpvg_pkg::AX_ROT) begin
            pass_q  <= cnt_ok && (hit_q || in_band);
            done_q  <= 1'b1;
            state_q <= L_IDLE;
          end else begin
            hit_q   <= hit_q || in_band;
            ax_q    <= ax_q + 1'b1;
            state_q <= L_MUL;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o       = done_q;
  assign stat_o.pass  = pass_q;
  assign stat_o.count = cnt_q;
  assign stat_o.sum   = sum_q;

endmodule

@@ design/dcpvg_merge.sv @@
`include "dual_camera_pose_variance_gate_defines.svh"

module dcpvg_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  dcpvg_pkg::lane_stat_t left_i,
  input  dcpvg_pkg::lane_stat_t right_i,
  input  logic                  ack_i,
  output logic                  done_o,
  output logic                  has_pose_o,
  output dcpvg_pkg::sample_t    pose_o,
  output logic [1:0]            source_o
);

  typedef enum logic [1:0] {M_IDLE, M_DIV, M_DONE} merge_state_e;

  merge_state_e                                        state_q;
  logic [dcpvg_pkg::STEP_W-1:0]                        step_q;
  logic                                                has_q;
  logic [1:0]                                          src_q;
  logic [dcpvg_pkg::NP_W-1:0]                          div_q;
  logic [dcpvg_pkg::AXES-1:0]                          neg_q;
  logic [dcpvg_pkg::AXES-1:0][dcpvg_pkg::SUMP_W-1:0]   quo_q;
  logic [dcpvg_pkg::AXES-1:0][dcpvg_pkg::NP_W-1:0]     rem_q;

  logic [dcpvg_pkg::AXES-1:0][dcpvg_pkg::SUMP_W-1:0]   lsum, rsum, ssum, mag;
  logic [dcpvg_pkg::AXES-1:0][dcpvg_pkg::NP_W:0]       rem_t;
  logic [dcpvg_pkg::AXES-1:0][dcpvg_pkg::SUMP_W-1:0]   signed_q;
  logic                                                lp, rp;
  logic [dcpvg_pkg::NP_W-1:0]                          n_sel;

  assign lp = left_i.pass;
  assign rp = right_i.pass;

  // pick the pooled or single window sums
  always_comb begin
    for (int k = 0; k < dcpvg_pkg::AXES; k++) begin
      lsum[k] = {left_i.sum[k][dcpvg_pkg::SUM_W-1], left_i.sum[k]};
      rsum[k] = {right_i.sum[k][dcpvg_pkg::SUM_W-1], right_i.sum[k]};
      if (lp && rp) begin
        ssum[k] = lsum[k] + rsum[k];
      end else if (lp) begin
        ssum[k] = lsum[k];
      end else begin
        ssum[k] = rsum[k];
      end
      mag[k] = ssum[k][dcpvg_pkg::SUMP_W-1] ? -ssum[k] : ssum[k];
    end
    if (lp && rp) begin
      n_sel = dcpvg_pkg::NP_W'(left_i.count) + dcpvg_pkg::NP_W'(right_i.count);
    end else if (lp) begin
      n_sel = dcpvg_pkg::NP_W'(left_i.count);
    end else begin
      n_sel = dcpvg_pkg::NP_W'(right_i.count);
    end
  end

  // restoring divide, one quotient bit per cycle on each axis
  always_comb begin
    for (int k = 0; k < dcpvg_pkg::AXES; k++) begin
      rem_t[k]    = {rem_q[k], quo_q[k][dcpvg_pkg::SUMP_W-1]};
      signed_q[k] = neg_q[k] ? -quo_q[k] : quo_q[k];
      pose_o[k]   = signed_q[k][dcpvg_pkg::SMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      step_q  <= '0;
      has_q   <= 1'b0;
      src_q   <= dcpvg_pkg::SRC_BOTH;
      div_q   <= '0;
      neg_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
    end else begin
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            has_q <= lp || rp;
            src_q <= (lp && rp) ? dcpvg_pkg::SRC_BOTH :
                     lp         ? dcpvg_pkg::SRC_LEFT : dcpvg_pkg::SRC_RIGHT;
            div_q  <= n_sel;
            step_q <= dcpvg_pkg::STEP_W'(dcpvg_pkg::SUMP_W - 1);
            rem_q  <= '0;
            for (int k = 0; k < dcpvg_pkg::AXES; k++) begin
              neg_q[k] <= ssum[k][dcpvg_pkg::SUMP_W-1];
              quo_q[k] <= mag[k];
            end
            state_q <= (lp || rp) ? M_DIV : M_DONE;
          end
        end
        M_DIV: begin
          for (int k = 0; k < dcpvg_pkg::AXES; k++) begin
            if (rem_t[k] >= {1'b0, div_q}) begin
              rem_q[k] <= dcpvg_pkg::NP_W'(rem_t[k] - {1'b0, div_q});
              quo_q[k] <= {quo_q[k][dcpvg_pkg::SUMP_W-2:0], 1'b1};
            end else begin
              rem_q[k] <= rem_t[k][dcpvg_pkg::NP_W-1:0];
              quo_q[k] <= {quo_q[k][dcpvg_pkg::SUMP_W-2:0], 1'b0};
            end
          end
          if (step_q == '0) begin
            state_q <= M_DONE;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        M_DONE: begin
          if (ack_i) begin
            state_q <= M_IDLE;
          end
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o     = (state_q == M_DONE);
  assign has_pose_o = has_q;
  assign source_o   = src_q;

  `DCPVG_ASSERT_CR(a_div_nonzero, (state_q == M_DIV) |-> (div_q != '0), "divide by zero count")
  `DCPVG_ASSERT_CR(a_start_idle, start_i |-> (state_q == M_IDLE), "merge started while busy")
  `DCPVG_ASSERT_CR(a_done_holds, (done_o && !ack_i) |=> done_o, "merge result dropped")

endmodule

@@ tb/sv/tb_dual_camera_pose_variance_gate.sv @@
module tb_dual_camera_pose_variance_gate;

  // index just past the register file, writes there must be dropped
  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam int unsigned RUN_LIMIT = 1500000;
  // settle time after the queue drains, covers a request that yields no pose
  localparam int unsigned SETTLE = 80;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        left_valid_i;
  logic [15:0] left_x_i;
  logic [15:0] left_y_i;
  logic [15:0] left_rot_i;
  logic        right_valid_i;
  logic [15:0] right_x_i;
  logic [15:0] right_y_i;
  logic [15:0] right_rot_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] pose_x_o;
  logic [15:0] pose_y_o;
  logic [15:0] pose_rot_o;
  logic [1:0]  pose_source_o;

  dual_camera_pose_variance_gate dut (.*);

  // one stored camera entry in the shadow windows
  typedef struct {
    bit      good;
    shortint x;
    shortint y;
    shortint rot;
  } slot_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] rot;
    logic [1:0]  src;
  } pose_t;

  slot_t       left_win  [dcpvg_pkg::DEPTH];
  slot_t       right_win [dcpvg_pkg::DEPTH];
  int unsigned ring_slot;
  logic [4:0]  min_good;
  logic [31:0] pos_lo, pos_hi, rot_lo, rot_hi;

  pose_t       pending_poses[$];
  int          errors;
  longint      cycles;
  bit          quiet;       // no receiver stalls while set
  int          stall_left;
  // per-phase cluster centers for well-formed windows
  int          ctr_x, ctr_y, ctr_rot, spread;

  // clock and cycle watchdog
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: mostly ready, short stalls, now and then a long one
  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                 : $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // pose checker against the oldest prediction
  always @(posedge clk_i) begin
    pose_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_poses.size() == 0) begin
        $error("pose with no request waiting for one");
        errors++;
      end else begin
        want = pending_poses.pop_front();
        if (pose_x_o !== want.x) begin
          $error("pose_x expected %h got %h", want.x, pose_x_o);
          errors++;
        end
        if (pose_y_o !== want.y) begin
          $error("pose_y expected %h got %h", want.y, pose_y_o);
          errors++;
        end
        if (pose_rot_o !== want.rot) begin
          $error("pose_rot expected %h got %h", want.rot, pose_rot_o);
          errors++;
        end
        if (pose_source_o !== want.src) begin
          $error("pose_source expected %0d got %0d", want.src, pose_source_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic void window_sums(input slot_t w[dcpvg_pkg::DEPTH], output longint cnt,
                                      output longint s[3], output longint q[3]);
    longint v[3];
    cnt = 0;
    for (int k = 0; k < 3; k++) begin
      s[k] = 0;
      q[k] = 0;
    end
    for (int i = 0; i < dcpvg_pkg::DEPTH; i++) begin
      if (w[i].good) begin
        v[0] = w[i].x;
        v[1] = w[i].y;
        v[2] = w[i].rot;
        cnt++;
        for (int k = 0; k < 3; k++) begin
          s[k] += v[k];
          q[k] += v[k] * v[k];
        end
      end
    end
  endfunction

  // population variance in [lo, hi], scaled by n*n to stay in integers
  function automatic bit var_in_band(longint cnt, longint s, longint q,
                                     logic [31:0] lo, logic [31:0] hi);
    longint unsigned scaled, nn;
    scaled = longint'(cnt * q - s * s);
    nn     = cnt * cnt;
    return scaled >= nn * lo && scaled <= nn * hi;
  endfunction

  function automatic bit window_ok(longint cnt, longint s[3], longint q[3]);
    if (cnt == 0 || cnt < min_good) return 1'b0;
    return var_in_band(cnt, s[0], q[0], pos_lo, pos_hi) ||
           var_in_band(cnt, s[1], q[1], pos_lo, pos_hi) ||
           var_in_band(cnt, s[2], q[2], rot_lo, rot_hi);
  endfunction

  // update shadow windows with an accepted request and queue its pose, if any
  function automatic void predict_pose(bit lv, logic [15:0] lx, logic [15:0] ly,
                                       logic [15:0] lr, bit rv, logic [15:0] rx,
                                       logic [15:0] ry, logic [15:0] rr);
    longint ln, rn, n;
    longint ls[3], lq[3], rs[3], rq[3], sum[3];
    bit     lp, rp;
    pose_t  p;
    if (lv || rv) begin
      left_win[ring_slot]  = '{lv, lx, ly, lr};
      right_win[ring_slot] = '{rv, rx, ry, rr};
      ring_slot = (ring_slot + 1) % dcpvg_pkg::DEPTH;
    end
    window_sums(left_win, ln, ls, lq);
    window_sums(right_win, rn, rs, rq);
    lp = window_ok(ln, ls, lq);
    rp = window_ok(rn, rs, rq);
    if (!lp && !rp) return;
    for (int k = 0; k < 3; k++)
      sum[k] = (lp ? ls[k] : 0) + (rp ? rs[k] : 0);
    n     = (lp ? ln : 0) + (rp ? rn : 0);
    p.x   = 16'(sum[0] / n);
    p.y   = 16'(sum[1] / n);
    p.rot = 16'(sum[2] / n);
    p.src = (lp && rp) ? dcpvg_pkg::SRC_BOTH
                       : (lp ? dcpvg_pkg::SRC_LEFT : dcpvg_pkg::SRC_RIGHT);
    pending_poses = {pending_poses, p};
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // one request: hold until accepted, then an optional gap
  task automatic send_sample(bit lv, logic [15:0] lx, logic [15:0] ly, logic [15:0] lr,
                             bit rv, logic [15:0] rx, logic [15:0] ry, logic [15:0] rr);
    int gap;
    in_valid_i    <= 1'b1;
    left_valid_i  <= lv;
    left_x_i      <= lx;
    left_y_i      <= ly;
    left_rot_i    <= lr;
    right_valid_i <= rv;
    right_x_i     <= rx;
    right_y_i     <= ry;
    right_rot_i   <= rr;
    do @(posedge clk_i); while (!in_ready_o);
    predict_pose(lv, lx, ly, lr, rv, rx, ry, rr);
    gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 2);
    if (quiet) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait until every pose has arrived and the block has gone quiet
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      dcpvg_pkg::REG_MIN_GOOD: min_good = val[4:0];
      dcpvg_pkg::REG_POS_LO:   pos_lo   = val;
      dcpvg_pkg::REG_POS_HI:   pos_hi   = val;
      dcpvg_pkg::REG_ROT_LO:   rot_lo   = val;
      dcpvg_pkg::REG_ROT_HI:   rot_hi   = val;
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [4:0] mg, logic [31:0] plo, logic [31:0] phi,
                         logic [31:0] rlo, logic [31:0] rhi);
    cfg_write(dcpvg_pkg::REG_MIN_GOOD, 32'(mg));
    cfg_write(dcpvg_pkg::REG_POS_LO, plo);
    cfg_write(dcpvg_pkg::REG_POS_HI, phi);
    cfg_write(dcpvg_pkg::REG_ROT_LO, rlo);
    cfg_write(dcpvg_pkg::REG_ROT_HI, rhi);
  endtask

  // sample value: mostly clustered near a center, some full-range noise
  function automatic logic [15:0] pick(int center, bit is_rot);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom());
    if (r == 1) return is_rot ? 16'($urandom_range(0, 36000) - 18000)
                              : (($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000);
    return 16'(center + $urandom_range(0, 2 * spread) - spread);
  endfunction

  task automatic send_random(int count, int valid_pct);
    bit lv, rv;
    for (int i = 0; i < count; i++) begin
      lv = $urandom_range(0, 99) < valid_pct;
      rv = $urandom_range(0, 99) < valid_pct;
      send_sample(lv, pick(ctr_x, 0), pick(ctr_y, 0), pick(ctr_rot, 1),
                  rv, pick(ctr_x + 40, 0), pick(ctr_y - 40, 0), pick(ctr_rot, 1));
    end
  endtask

  task automatic new_cluster(int s);
    ctr_x   = $urandom_range(0, 60000) - 30000;
    ctr_y   = $urandom_range(0, 60000) - 30000;
    ctr_rot = $urandom_range(0, 34000) - 17000;
    spread  = s;
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // extremes of every field at default registers, plus bad headings
  task automatic test_extremes;
    for (int i = 0; i < 8; i++)
      send_sample(1, 16'h7fff, 16'h8000, 16'(18000), 0, 16'h0, 16'h0, 16'h0);
    send_sample(1, 16'h8000, 16'h7fff, 16'(-18000), 1, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(0, 16'hffff, 16'hffff, 16'hffff, 0, 16'hffff, 16'hffff, 16'hffff);
    for (int i = 0; i < 8; i++)
      send_sample(0, 16'h1234, 16'h0, 16'h0, 1, 16'h8000, 16'h8000, 16'h8000);
    send_sample(1, 16'hffff, 16'h0001, 16'h8000, 1, 16'h0001, 16'hffff, 16'h7fff);
    drain();
  endtask

  // minimum count of one and zero, inverted bands, unmapped register write
  task automatic test_thresholds;
    cfg_all(5'd1, 32'd0, 32'd0, 32'd0, 32'd0);
    cfg_write(REG_UNUSED, 32'hdead_beef);
    new_cluster(0);
    send_random(20, 60);
    drain();
    cfg_all(5'd0, 32'd10, 32'd5, 32'hffff_ffff, 32'hffff_fffe);
    new_cluster(20);
    send_random(20, 60);
    drain();
    // all bands narrowed to the top value with a minimum count of 16
    cfg_all(5'd16, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_random(25, 95);
    drain();
  endtask

  // count above the window depth never passes
  task automatic test_count_over_depth;
    cfg_all(5'd31, 32'd0, 32'hffff_ffff, 32'd0, 32'hffff_ffff);
    send_random(20, 100);
    drain();
    cfg_write(dcpvg_pkg::REG_MIN_GOOD, 32'd17);
    send_random(10, 100);
    drain();
  endtask

  // narrow variance bands around clustered windows
  task automatic test_variance_bands;
    for (int ph = 0; ph < 8; ph++) begin
      new_cluster($urandom_range(1, 60));
      cfg_all(5'($urandom_range(1, 16)), $urandom_range(0, 400), $urandom_range(100, 1500),
              $urandom_range(0, 400), $urandom_range(100, 1500));
      quiet = (ph == 3);
      send_random(35, $urandom_range(50, 100));
      drain();
    end
    quiet = 0;
  endtask

  // full-range noise with open bands
  task automatic test_noise;
    cfg_all(5'd4, 32'd0, 32'hffff_ffff, 32'd0, 32'hffff_ffff);
    new_cluster(32767);
    send_random(80, 70);
    drain();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    left_valid_i  = 1'b0;
    left_x_i      = '0;
    left_y_i      = '0;
    left_rot_i    = '0;
    right_valid_i = 1'b0;
    right_x_i     = '0;
    right_y_i     = '0;
    right_rot_i   = '0;
    out_ready_i   = 1'b0;
    errors        = 0;
    cycles        = 0;
    quiet         = 0;
    stall_left    = 0;
    ring_slot     = 0;
    min_good      = 5'd8;
    pos_lo        = 32'd0;
    pos_hi        = 32'hffff_ffff;
    rot_lo        = 32'd0;
    rot_hi        = 32'hffff_ffff;
    for (int i = 0; i < dcpvg_pkg::DEPTH; i++) begin
      left_win[i]  = '{0, 0, 0, 0};
      right_win[i] = '{0, 0, 0, 0};
    end
    new_cluster(10);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_thresholds();
    test_count_over_depth();
    test_variance_bands();
    test_noise();

    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
